@@ hw/rtl/sensor_response_frame_parser_defines.svh @@
// Assertion macros shared by the sensor response frame parser RTL.
`ifndef SENSOR_RESPONSE_FRAME_PARSER_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define SRFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srfp check failed");

// Next-cycle implication, disabled during reset.
`define SRFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srfp check failed");

`else

`define SRFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define SRFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/srfp_pkg.sv @@
// Shared types and constants for the sensor response frame parser.
`timescale 1ns / 1ps

package srfp_pkg;

  // Reply bytes.
  localparam logic [7:0] ACK_BYTE    = 8'hA5;
  localparam logic [7:0] REFUSE_BYTE = 8'h96;
  localparam logic [7:0] HEADER_BYTE = 8'h40;

  // Length byte must stay below this value.
  localparam logic [7:0] FRAME_LIMIT = 8'd14;

  // Default number of payload bytes kept.
  localparam int STORED_PAYLOAD_DEFAULT = 4;

  // Status codes.
  localparam logic [1:0] ST_ACK     = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_BAD_SUM = 2'd3;

  // Widths of the stream words.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // One received byte with its side information.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_req;
    logic       timed_out;
    logic       expect_frame;
    logic [7:0] expected_code;
    logic [3:0] expected_payload;
    logic [3:0] payload_capacity;
  } srfp_item_t;

  // One parse result.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  response_code;
    logic [3:0]  payload_length;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } srfp_result_t;

endpackage

@@ hw/rtl/sensor_response_frame_parser.sv @@
// Top level of the sensor response frame parser.
//
//   Channel  Dir  Contents
//   s_*      in   one received byte with start, timeout and expected-frame info
//   m_*      out  one reply result: status, code, length and two payload words
//
// Each item is held in the input register, where the parser decides its
// effect; the result is then loaded into the output register, so m_tvalid rises
// after the completing item has passed the input and then the output register.
// One item per cycle is sustained while the sink keeps m_tready high.
// The input register waits only while a result is stalled in the output register.
// Reset is synchronous: the parser returns to idle and both registers empty.
`timescale 1ns / 1ps
`include "sensor_response_frame_parser_defines.svh"

module sensor_response_frame_parser #(
  parameter int STORED_PAYLOAD = srfp_pkg::STORED_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // rx_byte[7:0], expected_code[15:8], expected_payload[19:16],
  // payload_capacity[23:20]
  input  logic [srfp_pkg::IN_DATA_W-1:0]  s_tdata,
  // start_req[0], timed_out[1], expect_frame[2]
  input  logic [srfp_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // response_code[7:0], payload_length[11:8], first_word[27:12],
  // second_word[43:28], zero fill[47:44]
  output logic [srfp_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [srfp_pkg::OUT_USER_W-1:0] m_tuser
);
  import srfp_pkg::*;

  logic         in_valid;
  srfp_item_t   in_item;
  logic         out_free;
  logic         advance;
  logic         res_valid;
  srfp_result_t result;

  // The held item is handled once the output register has room.
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.rx_byte          <= s_tdata[7:0];
      in_item.expected_code    <= s_tdata[15:8];
      in_item.expected_payload <= s_tdata[19:16];
      in_item.payload_capacity <= s_tdata[23:20];
      in_item.start_req        <= s_tuser[0];
      in_item.timed_out        <= s_tuser[1];
      in_item.expect_frame     <= s_tuser[2];
    end
  end

  srfp_parser #(
    .STORED_PAYLOAD(STORED_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (in_item),
    .res_valid(res_valid),
    .result   (result)
  );

  srfp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && res_valid),
    .result  (result),
    .free    (out_free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

  `SRFP_ASSERT_NEXT(a_item_kept, clk, rst, in_valid && !out_free, in_valid)
  `SRFP_ASSERT_NEXT(a_result_shown, clk, rst, advance && res_valid, m_tvalid)
  `SRFP_ASSERT_NEXT(a_result_gone, clk, rst,
                    m_tvalid && m_tready && !(advance && res_valid), !m_tvalid)

endmodule

@@ hw/rtl/srfp_parser.sv @@
// Reply parser: phase state, checksum, payload store and result decode.
`timescale 1ns / 1ps
`include "sensor_response_frame_parser_defines.svh"

module srfp_parser #(
  parameter int STORED_PAYLOAD = srfp_pkg::STORED_PAYLOAD_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  srfp_pkg::srfp_item_t item,
  output logic                 res_valid,
  output srfp_pkg::srfp_result_t result
);
  import srfp_pkg::*;

  localparam int IDX_W = $clog2(STORED_PAYLOAD);

  // Phase codes.
  localparam logic [2:0] PH_IDLE          = 3'd0;
  localparam logic [2:0] PH_SIMPLE_SECOND = 3'd1;
  localparam logic [2:0] PH_FRAME_SECOND  = 3'd2;
  localparam logic [2:0] PH_FRAME_CODE    = 3'd3;
  localparam logic [2:0] PH_FRAME_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_FRAME_CHECK   = 3'd5;

  logic [2:0] phase, phase_next;
  logic [7:0] held_first_byte, held_first_byte_next;
  logic [3:0] frame_length, frame_length_next;
  logic [3:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] echoed_code, echoed_code_next;
  logic [7:0] payload_store [STORED_PAYLOAD];

  logic [3:0] store_idx;
  logic       store_we;
  logic [3:0] len;
  logic [7:0] want_sum;
  logic [7:0] b;

  assign b         = item.rx_byte;
  assign len       = frame_length - 4'd1;
  assign want_sum  = ~running_sum + 8'd1;
  assign store_idx = frame_length - 4'd1 - bytes_left;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_next           = phase;
    held_first_byte_next = held_first_byte;
    frame_length_next    = frame_length;
    bytes_left_next      = bytes_left;
    running_sum_next     = running_sum;
    echoed_code_next     = echoed_code;
    store_we             = 1'b0;
    res_valid            = 1'b0;
    result               = '0;

    if (item.timed_out) begin
      if (item.start_req || phase != PH_IDLE) begin
        res_valid     = 1'b1;
        result.status = ST_BAD;
        phase_next    = PH_IDLE;
      end
    end else if (item.start_req) begin
      held_first_byte_next = b;
      frame_length_next    = 4'd0;
      bytes_left_next      = 4'd0;
      running_sum_next     = 8'd0;
      echoed_code_next     = 8'd0;
      phase_next           = item.expect_frame ? PH_FRAME_SECOND : PH_SIMPLE_SECOND;
    end else begin
      unique case (phase)
        PH_SIMPLE_SECOND: begin
          res_valid  = 1'b1;
          phase_next = PH_IDLE;
          if (held_first_byte == ACK_BYTE && b == ACK_BYTE) begin
            result.status = ST_ACK;
          end else if (held_first_byte == REFUSE_BYTE && b == REFUSE_BYTE) begin
            result.status = ST_REFUSED;
          end else begin
            result.status = ST_BAD;
          end
        end
        PH_FRAME_SECOND: begin
          if (held_first_byte == REFUSE_BYTE && b == REFUSE_BYTE) begin
            res_valid     = 1'b1;
            result.status = ST_REFUSED;
            phase_next    = PH_IDLE;
          end else if (held_first_byte != HEADER_BYTE || b == 8'd0 || b >= FRAME_LIMIT ||
                       b > 8'd15 || (b - 8'd1) > {4'd0, item.payload_capacity}) begin
            res_valid     = 1'b1;
            result.status = ST_BAD;
            phase_next    = PH_IDLE;
          end else begin
            frame_length_next = b[3:0];
            running_sum_next  = HEADER_BYTE + b;
            phase_next        = PH_FRAME_CODE;
          end
        end
        PH_FRAME_CODE: begin
          echoed_code_next = b;
          running_sum_next = running_sum + b;
          bytes_left_next  = len;
          phase_next       = (len == 4'd0) ? PH_FRAME_CHECK : PH_FRAME_PAYLOAD;
        end
        PH_FRAME_PAYLOAD: begin
          store_we         = (store_idx < 4'(STORED_PAYLOAD));
          running_sum_next = running_sum + b;
          bytes_left_next  = bytes_left - 4'd1;
          if (bytes_left == 4'd1) begin
            phase_next = PH_FRAME_CHECK;
          end
        end
        PH_FRAME_CHECK: begin
          res_valid             = 1'b1;
          phase_next            = PH_IDLE;
          result.response_code  = echoed_code;
          result.payload_length = len;
          if (b != want_sum) begin
            result.status = ST_BAD_SUM;
          end else if (echoed_code != item.expected_code || len != item.expected_payload) begin
            result.status = ST_BAD;
          end else begin
            result.status = ST_ACK;
            if (len == 4'd1) begin
              result.first_word = {8'd0, payload_store[0]};
            end else if (len >= 4'd2) begin
              result.first_word = {payload_store[0], payload_store[1]};
            end
            if (len == 4'd3) begin
              result.second_word = {8'd0, payload_store[2]};
            end else if (len >= 4'd4) begin
              result.second_word = {payload_store[2], payload_store[3]};
            end
          end
        end
        default: begin
          // Idle without a start flag: the byte is dropped.
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      held_first_byte <= 8'd0;
      frame_length    <= 4'd0;
      bytes_left      <= 4'd0;
      running_sum     <= 8'd0;
      echoed_code     <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      held_first_byte <= held_first_byte_next;
      frame_length    <= frame_length_next;
      bytes_left      <= bytes_left_next;
      running_sum     <= running_sum_next;
      echoed_code     <= echoed_code_next;
    end
  end

  // Payload store keeps the first payload bytes of the frame.
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      payload_store[store_idx[IDX_W-1:0]] <= b;
    end
  end

  `SRFP_ASSERT_NEXT(a_idle_after_result, clk, rst, step && res_valid, phase == PH_IDLE)
  `SRFP_ASSERT_NOW(a_payload_has_bytes, clk, rst, phase == PH_FRAME_PAYLOAD, bytes_left != 4'd0)
  `SRFP_ASSERT_NOW(a_frame_len_set, clk, rst,
                   phase == PH_FRAME_CODE || phase == PH_FRAME_PAYLOAD ||
                   phase == PH_FRAME_CHECK, frame_length != 4'd0)

endmodule

@@ hw/rtl/srfp_out_stage.sv @@
// Output register that holds one result until the sink takes it.
`timescale 1ns / 1ps

module srfp_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  srfp_pkg::srfp_result_t result,
  output logic                   free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [srfp_pkg::OUT_USER_W-1:0] m_tuser,
  output logic [srfp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import srfp_pkg::*;

  srfp_result_t held;

  // Room for a new result when empty or when the current one leaves now.
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tuser = held.status;
  assign m_tdata = {4'd0, held.second_word, held.first_word, held.payload_length,
                    held.response_code};

endmodule

@@ test/tb_top.sv @@
// Testbench for the sensor response frame parser: directed and random replies checked per field.
`timescale 1ns / 1ps

module tb_top;
  import srfp_pkg::*;

  localparam int STORE_DEPTH    = STORED_PAYLOAD_DEFAULT;
  localparam int KEEP_IDX_W     = $clog2(STORE_DEPTH);
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 1000;

  // Parser phases of the local model.
  typedef enum logic [2:0] {
    RX_IDLE,
    RX_SIMPLE_2ND,
    RX_LEN,
    RX_CODE,
    RX_PAYLOAD,
    RX_SUM
  } reply_phase_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // Local parser state.
  reply_phase_t rx_phase = RX_IDLE;
  logic [7:0]   held_byte = '0;
  logic [3:0]   frame_len = '0;
  logic [3:0]   left_bytes = '0;
  logic [7:0]   run_sum = '0;
  logic [7:0]   echo_code = '0;
  logic [7:0]   kept_bytes [STORE_DEPTH];

  srfp_result_t pending_replies[$];
  int           bytes_sent = 0;
  int           mismatches = 0;
  bit           idle_bursts = 1'b0;
  bit           hold_requested = 1'b0;

  sensor_response_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the reply result, if any, that one received byte completes.
  task automatic parse_reply_byte(input srfp_item_t it, output bit has_result,
                                  output srfp_result_t res);
    logic [3:0] idx;
    logic [3:0] len;
    logic [7:0] want_sum;
    has_result = 1'b0;
    res = '0;
    if (it.timed_out) begin
      // A timeout only ends a reply that is active or just starting.
      if (it.start_req || rx_phase != RX_IDLE) begin
        has_result = 1'b1;
        res.status = ST_BAD;
        rx_phase = RX_IDLE;
      end
    end else if (it.start_req) begin
      held_byte = it.rx_byte;
      frame_len = '0;
      left_bytes = '0;
      run_sum = '0;
      echo_code = '0;
      rx_phase = it.expect_frame ? RX_LEN : RX_SIMPLE_2ND;
    end else begin
      case (rx_phase)
        RX_SIMPLE_2ND: begin
          has_result = 1'b1;
          rx_phase = RX_IDLE;
          if (held_byte == ACK_BYTE && it.rx_byte == ACK_BYTE) res.status = ST_ACK;
          else if (held_byte == REFUSE_BYTE && it.rx_byte == REFUSE_BYTE)
            res.status = ST_REFUSED;
          else res.status = ST_BAD;
        end
        RX_LEN: begin
          if (held_byte == REFUSE_BYTE && it.rx_byte == REFUSE_BYTE) begin
            has_result = 1'b1;
            res.status = ST_REFUSED;
            rx_phase = RX_IDLE;
          end else if (held_byte != HEADER_BYTE || it.rx_byte == 8'd0 ||
                       it.rx_byte >= FRAME_LIMIT || it.rx_byte > 8'd15 ||
                       int'(it.rx_byte) - 1 > int'(it.payload_capacity)) begin
            has_result = 1'b1;
            res.status = ST_BAD;
            rx_phase = RX_IDLE;
          end else begin
            frame_len = it.rx_byte[3:0];
            run_sum = HEADER_BYTE + it.rx_byte;
            rx_phase = RX_CODE;
          end
        end
        RX_CODE: begin
          echo_code = it.rx_byte;
          run_sum = run_sum + it.rx_byte;
          left_bytes = frame_len - 4'd1;
          rx_phase = (left_bytes == 4'd0) ? RX_SUM : RX_PAYLOAD;
        end
        RX_PAYLOAD: begin
          // Bytes past the stored ones only count toward the checksum.
          idx = frame_len - 4'd1 - left_bytes;
          if (idx < STORE_DEPTH) kept_bytes[idx[KEEP_IDX_W-1:0]] = it.rx_byte;
          run_sum = run_sum + it.rx_byte;
          left_bytes = left_bytes - 4'd1;
          if (left_bytes == 4'd0) rx_phase = RX_SUM;
        end
        RX_SUM: begin
          len = frame_len - 4'd1;
          want_sum = 8'd0 - run_sum;
          has_result = 1'b1;
          rx_phase = RX_IDLE;
          res.response_code = echo_code;
          res.payload_length = len;
          if (it.rx_byte != want_sum) begin
            res.status = ST_BAD_SUM;
          end else if (echo_code != it.expected_code || len != it.expected_payload) begin
            res.status = ST_BAD;
          end else begin
            res.status = ST_ACK;
            if (len == 4'd1) res.first_word = {8'd0, kept_bytes[0]};
            else if (len >= 4'd2) res.first_word = {kept_bytes[0], kept_bytes[1]};
            if (len == 4'd3) res.second_word = {8'd0, kept_bytes[2]};
            else if (len >= 4'd4) res.second_word = {kept_bytes[2], kept_bytes[3]};
          end
        end
        default: ;
      endcase
    end
  endtask

  // One byte with random side fields in their legal ranges.
  function automatic srfp_item_t make_item(input logic [7:0] b, input bit start,
                                           input bit frame);
    srfp_item_t it;
    it.rx_byte = b;
    it.start_req = start;
    it.timed_out = 1'b0;
    it.expect_frame = frame;
    it.expected_code = 8'($urandom);
    it.expected_payload = 4'($urandom_range(0, 8));
    it.payload_capacity = 4'($urandom_range(1, 8));
    return it;
  endfunction

  function automatic logic [7:0] reply_byte();
    case ($urandom_range(0, 2))
      0: return ACK_BYTE;
      1: return REFUSE_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item, wait for the handshake and record what it should produce.
  task automatic send_byte(input srfp_item_t it);
    bit           has_result;
    srfp_result_t res;
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.payload_capacity, it.expected_payload, it.expected_code, it.rx_byte};
    s_tuser <= {it.expect_frame, it.timed_out, it.start_req};
    do @(posedge clk); while (!s_tready);
    parse_reply_byte(it, has_result, res);
    if (has_result) pending_replies.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every pending reply result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_timeout(input bit start);
    srfp_item_t it;
    it = make_item(8'($urandom), start, 1'($urandom_range(0, 1)));
    it.timed_out = 1'b1;
    send_byte(it);
  endtask

  task automatic send_simple(input logic [7:0] b0, input logic [7:0] b1);
    send_byte(make_item(b0, 1'b1, 1'b0));
    send_byte(make_item(b1, 1'b0, 1'($urandom_range(0, 1))));
  endtask

  // A byte inside a frame, carrying the values the frame is checked against.
  task automatic frame_byte(input logic [7:0] b, input logic [7:0] want_code,
                            input logic [3:0] want_len, input logic [3:0] cap);
    srfp_item_t it;
    it = make_item(b, 1'b0, 1'($urandom_range(0, 1)));
    it.expected_code = want_code;
    it.expected_payload = want_len;
    it.payload_capacity = cap;
    send_byte(it);
  endtask

  // A two-byte frame-mode opening: the first byte and what stands as the length.
  task automatic send_header(input logic [7:0] first_b, input logic [7:0] second_b,
                             input logic [3:0] cap);
    send_byte(make_item(first_b, 1'b1, 1'b1));
    frame_byte(second_b, 8'($urandom), 4'($urandom_range(0, 8)), cap);
  endtask

  // A complete data frame; the checksum can be spoiled on request.
  task automatic send_frame(input logic [7:0] code, input int plen, input logic [3:0] cap,
                            input logic [7:0] want_code, input logic [3:0] want_len,
                            input bit bad_sum, input bit all_ones);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] len_byte;
    len_byte = 8'(plen + 1);
    sum = HEADER_BYTE + len_byte + code;
    send_byte(make_item(HEADER_BYTE, 1'b1, 1'b1));
    frame_byte(len_byte, want_code, want_len, cap);
    frame_byte(code, want_code, want_len, cap);
    for (int i = 0; i < plen; i++) begin
      b = all_ones ? 8'hff : 8'($urandom);
      sum = sum + b;
      frame_byte(b, want_code, want_len, cap);
    end
    b = 8'd0 - sum;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    frame_byte(b, want_code, want_len, cap);
  endtask

  // One random reply: data frames, simple replies, broken or cut-short frames and noise.
  task automatic send_random_reply();
    int         kind;
    int         plen;
    int         cut;
    logic [3:0] cap;
    logic [3:0] want_len;
    logic [7:0] code;
    logic [7:0] want_code;
    logic [7:0] len_byte;
    logic [7:0] first_b;
    srfp_item_t it;
    kind = $urandom_range(0, 99);
    plen = $urandom_range(0, 8);
    code = 8'($urandom);
    cap = 4'($urandom_range(8, (plen > 1) ? plen : 1));
    if (kind < 45) begin
      want_code = ($urandom_range(0, 9) == 0) ? code ^ 8'($urandom_range(1, 255)) : code;
      want_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 8)) : 4'(plen);
      send_frame(code, plen, cap, want_code, want_len, $urandom_range(0, 9) == 0, 1'b0);
    end else if (kind < 60) begin
      send_simple(reply_byte(), reply_byte());
    end else if (kind < 67) begin
      send_header(REFUSE_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : REFUSE_BYTE,
                  cap);
    end else if (kind < 75) begin
      // Length byte that must be refused as soon as it arrives.
      cap = 4'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: len_byte = 8'd0;
        1: len_byte = FRAME_LIMIT + 8'($urandom_range(0, 1));
        2: len_byte = 8'($urandom_range(16, 255));
        default: len_byte = 8'($urandom_range(13, cap + 2));
      endcase
      send_header(HEADER_BYTE, len_byte, cap);
    end else if (kind < 80) begin
      first_b = 8'($urandom);
      if (first_b == HEADER_BYTE) first_b = first_b ^ 8'h01;
      send_header(first_b, 8'($urandom_range(1, 9)), 4'd8);
    end else if (kind < 88) begin
      // Frame cut short, then ended by a timeout or by the next start.
      send_byte(make_item(HEADER_BYTE, 1'b1, 1'b1));
      frame_byte(8'(plen + 1), code, 4'(plen), cap);
      cut = $urandom_range(0, plen);
      repeat (cut) frame_byte(8'($urandom), code, 4'(plen), cap);
      if ($urandom_range(0, 1) == 1) send_timeout(1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        it = make_item(8'($urandom), $urandom_range(0, 7) == 0,
                       1'($urandom_range(0, 1)));
        it.timed_out = ($urandom_range(0, 15) == 0);
        send_byte(it);
      end
    end
  endtask

  // Simple-mode replies and the idle, restart and timeout cases.
  task automatic test_simple_replies();
    srfp_item_t it;
    idle_bursts = 1'b0;
    send_byte(make_item(ACK_BYTE, 1'b0, 1'b0));
    it = make_item(8'h00, 1'b0, 1'b0);
    it.timed_out = 1'b1;
    send_byte(it);
    send_simple(ACK_BYTE, ACK_BYTE);
    send_simple(REFUSE_BYTE, REFUSE_BYTE);
    send_simple(ACK_BYTE, REFUSE_BYTE);
    send_byte(make_item(HEADER_BYTE, 1'b1, 1'b1));
    send_simple(ACK_BYTE, ACK_BYTE);
    it = make_item(8'hff, 1'b1, 1'b1);
    it.timed_out = 1'b1;
    send_byte(it);
  endtask

  // Frame-mode refusal, header and length errors, and an eight-byte all-ones payload.
  task automatic test_frame_replies();
    send_header(REFUSE_BYTE, REFUSE_BYTE, 4'd8);
    send_header(HEADER_BYTE ^ 8'h01, 8'd2, 4'd8);
    send_header(HEADER_BYTE, 8'd0, 4'd8);
    send_header(HEADER_BYTE, FRAME_LIMIT, 4'd8);
    send_frame(8'hff, 8, 4'd8, 8'hff, 4'd8, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_bytes, input bit bursts);
    int target;
    target = bytes_sent + n_bytes;
    idle_bursts = bursts;
    while (bytes_sent < target) send_random_reply();
  endtask

  // Sender drains first, then the sink holds off while replies keep coming.
  task automatic test_backpressure();
    idle_bursts = 1'b0;
    wait_drained();
    @(posedge clk);
    hold_requested = 1'b1;
    @(negedge clk);
    repeat (12) send_simple(reply_byte(), reply_byte());
    repeat (4) send_random_reply();
    wait_drained();
  endtask

  // Result sink with random stalls and the long hold.
  initial begin : result_sink
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_requested) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_requested = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest pending reply.
  always @(posedge clk) begin : result_check
    srfp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status %0d, data 0x%0h", m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("response_code", 32'(want.response_code), 32'(m_tdata[7:0]));
        check_field("payload_length", 32'(want.payload_length), 32'(m_tdata[11:8]));
        check_field("first_word", 32'(want.first_word), 32'(m_tdata[27:12]));
        check_field("second_word", 32'(want.second_word), 32'(m_tdata[43:28]));
      end
    end
  end

  // End the run if nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_simple_replies();
    test_frame_replies();
    test_random_traffic(450, 1'b1);
    test_backpressure();
    test_random_traffic(350, 1'b1);
    test_random_traffic(220, 1'b0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
